### design/sflc_pkg.sv
// Shared widths and constants for the lift-coefficient airspeed unit.
`default_nettype none
package sflc_pkg;
  localparam int CoeffW = 16;
  localparam int SpeedW = 16;
  localparam int QuotW  = 31;
  localparam int RootW  = 16;
  localparam logic [QuotW-1:0] Numer = 31'h4000_0000;

  typedef logic [QuotW-1:0] quot_t;
endpackage
`default_nettype wire

### design/sflc_div.sv
// Pipelined restoring divider: 2^30 / coefficient, one quotient bit per stage.
`default_nettype none
module sflc_div
  import sflc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [CoeffW-1:0] in_coeff,
  output logic                   out_valid,
  output quot_t                  out_quot
);
  logic [QuotW:0]      vld_r;
  logic [CoeffW-1:0]   den_r [QuotW+1];
  logic [CoeffW:0]     rem_r [QuotW+1];
  quot_t               quo_r [QuotW+1];

  always_comb begin
    vld_r[0] = in_valid;
    den_r[0] = in_coeff;
    rem_r[0] = '0;
    quo_r[0] = '0;
  end

  for (genvar s = 0; s < QuotW; s++) begin : g_stage
    logic [CoeffW:0] trial_nxt;
    logic            ge_nxt;
    always_comb begin
      trial_nxt = {rem_r[s][CoeffW-1:0], Numer[QuotW-1-s]};
      ge_nxt    = trial_nxt >= {1'b0, den_r[s]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= vld_r[s];
      end
      if (en) begin
        den_r[s+1] <= den_r[s];
        rem_r[s+1] <= ge_nxt ? trial_nxt - {1'b0, den_r[s]} : trial_nxt;
        quo_r[s+1] <= {quo_r[s][QuotW-2:0], ge_nxt};
      end
    end
  end

  assign out_valid = vld_r[QuotW];
  assign out_quot  = quo_r[QuotW];
endmodule
`default_nettype wire

### design/sflc_sqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
`default_nettype none
module sflc_sqrt
  import sflc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  quot_t                 in_quot,
  output logic                  out_valid,
  output logic [SpeedW-1:0]     out_root
);
  localparam int Steps = RootW;
  logic [Steps:0]    vld_r;
  logic [31:0]       rad_r [Steps+1];
  logic [RootW+2:0]  rem_r [Steps+1];
  logic [RootW:0]    root_r [Steps+1];

  always_comb begin
    vld_r[0]  = in_valid;
    rad_r[0]  = {1'b0, in_quot};
    rem_r[0]  = '0;
    root_r[0] = '0;
  end

  for (genvar s = 0; s < Steps; s++) begin : g_stage
    logic [RootW+2:0] acc_nxt;
    logic [RootW+2:0] trial_nxt;
    logic             ge_nxt;
    always_comb begin
      acc_nxt   = {rem_r[s][RootW:0], rad_r[s][31:30]};
      trial_nxt = {root_r[s], 2'b01};
      ge_nxt    = acc_nxt >= trial_nxt;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= vld_r[s];
      end
      if (en) begin
        rad_r[s+1]  <= {rad_r[s][29:0], 2'b00};
        rem_r[s+1]  <= ge_nxt ? acc_nxt - trial_nxt : acc_nxt;
        root_r[s+1] <= {root_r[s][RootW-1:0], ge_nxt};
      end
    end
  end

  assign out_valid = vld_r[Steps];
  assign out_root  = root_r[Steps][SpeedW-1:0];
endmodule
`default_nettype wire

### design/speed_for_lift_coefficient_unit.sv
// Top level: airspeed = floor(sqrt(2^30 / lift_coeff)) for positive coefficients.
// Usage:
//   Input word: in_lift_coeff (signed 8.8) on in_valid/in_ready.
//   Result word: out_airspeed on out_valid/out_ready, one per input word.
//   Not-positive coefficients give 0 (divisor forced to 1 so the divider
//   stays defined; a delayed flag zeroes the root at the output).
//   The divider is 31 stages (one quotient bit each), the square root 16
//   stages (one root bit each), then an output register.
//   A new word may enter every cycle while in_ready is high; throughput 1 word per cycle.
//   When the receiver stalls with the output register full, the whole
//   pipeline holds; in_ready drops and nothing is lost or repeated.
//   Reset (synchronous, rst_n low) clears all valid bits; payload is not reset.
`default_nettype none
module speed_for_lift_coefficient_unit
  import sflc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [CoeffW-1:0] in_lift_coeff,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [SpeedW-1:0]             out_airspeed
);
  logic        en;
  logic        div_valid;
  quot_t       div_quot;
  logic        sq_valid;
  logic [SpeedW-1:0] sq_root;
  logic        pos;
  logic        out_valid_r;
  logic [SpeedW-1:0] out_airspeed_r;
  logic [46:0] zero_r;
  logic [46:0] zero_nxt;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;
  assign pos      = (in_lift_coeff != '0) && !in_lift_coeff[CoeffW-1];
  assign zero_nxt = {zero_r[45:0], !pos};

  sflc_div u_div (
    .clk, .rst_n, .en,
    .in_valid (in_valid && in_ready),
    .in_coeff (pos ? in_lift_coeff : 16'h0001),
    .out_valid(div_valid),
    .out_quot (div_quot)
  );

  sflc_sqrt u_sqrt (
    .clk, .rst_n, .en,
    .in_valid (div_valid),
    .in_quot  (div_quot),
    .out_valid(sq_valid),
    .out_root (sq_root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r <= zero_nxt;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sq_valid;
    end
    if (en) begin
      out_airspeed_r <= zero_r[46] ? '0 : sq_root;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_airspeed = out_airspeed_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_airspeed))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("ready not tied to output slot");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_airspeed <= 16'h8000)
    else $error("airspeed out of range");
endmodule
`default_nettype wire
